### rtl/core/ptb_pkg.sv
// Types, state codes and constants shared by the phaser/tremolo/bitcrush core.
package ptb_pkg;

    typedef struct packed {
        logic signed [11:0] audio_in;
        logic [11:0]        rate_knob;
        logic [11:0]        depth_knob;
        logic [11:0]        texture_knob;
        logic signed [11:0] depth_cv;
        logic signed [11:0] texture_cv;
        logic [1:0]         mode_switch;
        logic               sync_pulse;
    } t_in_req;

    typedef struct packed {
        logic signed [11:0] audio_out;
        logic signed [11:0] phaser_lfo;
        logic signed [11:0] trem_lfo;
        logic               burst_flag;
        logic               lfo_pulse;
        logic [11:0]        led_rate;
        logic [11:0]        led_lfo;
        logic [11:0]        led_sweep;
        logic [11:0]        led_corruption;
        logic               led_burst;
        logic               led_pulse;
    } t_out_req;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RR, ST_RRK, ST_TR, ST_PD, ST_TD, ST_GAIN, ST_AG, ST_LCG, ST_LCGW,
        ST_AP_A, ST_AP_B, ST_AP_C, ST_PH, ST_DC, ST_DCW, ST_MIX, ST_HOLD,
        ST_SW, ST_SW2, ST_SW3, ST_SW4, ST_FIN
    } t_state;

    localparam logic [1:0]         MODE_MIX   = 2'd1;
    localparam logic [31:0]        PINC_BASE  = 32'd4473;
    localparam logic [31:0]        PINC_BURST = 32'd1073741;
    localparam logic [31:0]        TINC_BASE  = 32'd44739;
    localparam logic [31:0]        TINC_BURST = 32'd50000;
    localparam logic signed [24:0] PINC_K     = 25'sd2081;
    localparam logic signed [24:0] TINC_K     = 25'sd426;
    localparam logic signed [24:0] LCG_MUL    = 25'sd1664525;
    localparam logic [31:0]        LCG_ADD    = 32'd1013904223;
    localparam logic signed [13:0] SWEEP_MID  = 14'sd1500;
    localparam logic signed [13:0] SWEEP_MIN  = 14'sd200;
    localparam logic signed [13:0] SWEEP_MAX  = 14'sd2800;
    localparam logic signed [13:0] GAIN_MID   = 14'sd2048;
    localparam logic [13:0]        CORR_BURST = 14'd1500;
    localparam logic [13:0]        CORR_MAX   = 14'd4095;
    localparam logic signed [24:0] LED_K      = 25'sd4095;
    // floor(2^34 / 3000): quotient estimate low by at most one
    localparam logic signed [24:0] DIV_M      = 25'sd5726623;
    localparam logic signed [24:0] DIV_D      = 25'sd3000;
    localparam logic [23:0]        DIV_D24    = 24'd3000;

    function automatic logic signed [11:0] tri_wave(input logic [31:0] p);
        logic [10:0] x;
        x = p[31] ? ~p[30:20] : p[30:20];
        return $signed({~x[10], x[9:0], 1'b0});
    endfunction

    function automatic logic [11:0] clamp12(input logic signed [13:0] v);
        if (v < 14'sd0) return 12'd0;
        else if (v > 14'sd4095) return 12'd4095;
        else return v[11:0];
    endfunction

endpackage

### rtl/core/phaser_tremolo_bitcrush_sample_core.sv
// Top level: phaser / tremolo / bitcrush voice processing one audio sample per request.
// One input request is taken at a time, and the next request can be accepted in the cycle
// after the result is loaded into the output register. Processing uses a single shared
// 33x25 signed multiplier with a registered product, stepped by a sequencer: each allpass
// stage passes through ST_AP_A, ST_AP_B and ST_AP_C, and the other multiplier uses are the
// phase increments, LFO depth scaling, tremolo gain, the LCG and the sweep LED scaling. The
// output register lets a finished result wait while the next request is already being processed.
module phaser_tremolo_bitcrush_sample_core #(
    parameter int ALLPASS_STAGES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptb_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ptb_pkg::t_out_req o_out_req
);
    import ptb_pkg::*;

    localparam int STG_W = (ALLPASS_STAGES > 1) ? $clog2(ALLPASS_STAGES) : 1;

    t_state r_state, n_state;

    logic signed [11:0] r_ain;
    logic [11:0]        r_rate, r_depth, r_tex;
    logic [1:0]         r_mode;
    logic               r_sync, r_last_sync;
    logic [31:0]        r_pph, r_tph, r_lcg;
    logic signed [11:0] r_plfo, r_tlfo;
    logic [11:0]        r_sweep, r_gain, r_corr, r_lsw, r_q0;
    logic signed [13:0] r_trem;
    logic signed [31:0] r_x, r_acc, r_ph, r_dc, r_o, r_held, r_last;
    logic signed [31:0] r_pin  [ALLPASS_STAGES];
    logic signed [31:0] r_pout [ALLPASS_STAGES];
    logic [STG_W-1:0]   r_stg;
    logic [4:0]         r_hcnt;
    logic [23:0]        r_p;
    logic signed [57:0] r_prod;
    logic               r_out_valid;
    t_out_req           r_out;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic               burst, accept, out_free, last_stg;
    logic signed [13:0] dsum, tsum, swp, gsum;
    logic signed [31:0] y, ph7, outv, masked;
    logic signed [32:0] ddiff;
    logic signed [44:0] mix;
    logic [13:0]        corr;
    logic [4:0]         hnext;
    logic [23:0]        rem;
    logic [31:0]        mask;
    logic signed [15:0] a7;

    assign burst    = r_mode[1];
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_stg = (r_stg == STG_W'(ALLPASS_STAGES - 1));
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_RR;
            ST_RR: begin
                mul_a = {21'd0, r_rate};
                mul_b = {13'd0, r_rate};
                n_state = ST_RRK;
            end
            ST_RRK: begin
                mul_a = {9'd0, r_prod[23:0]};
                mul_b = PINC_K;
                n_state = ST_TR;
            end
            ST_TR: begin
                mul_a = {21'd0, r_rate};
                mul_b = TINC_K;
                n_state = ST_PD;
            end
            ST_PD: begin
                mul_a = 33'(tri_wave(r_pph));
                mul_b = {13'd0, r_depth};
                n_state = ST_TD;
            end
            ST_TD: begin
                mul_a = 33'(tri_wave(r_tph));
                mul_b = {13'd0, r_depth};
                n_state = ST_GAIN;
            end
            ST_GAIN: n_state = ST_AG;
            ST_AG: begin
                mul_a = 33'(r_ain);
                mul_b = {13'd0, r_gain};
                n_state = ST_LCG;
            end
            ST_LCG: begin
                mul_a = {1'b0, r_lcg};
                mul_b = LCG_MUL;
                n_state = ST_LCGW;
            end
            ST_LCGW: n_state = ST_AP_A;
            ST_AP_A: begin
                mul_a = 33'(r_pout[r_stg]);
                mul_b = {13'd0, r_sweep};
                n_state = ST_AP_B;
            end
            ST_AP_B: begin
                mul_a = 33'(r_x);
                mul_b = {13'd0, r_sweep};
                n_state = ST_AP_C;
            end
            ST_AP_C: n_state = last_stg ? ST_PH : ST_AP_A;
            ST_PH:   n_state = ST_DC;
            ST_DC:   n_state = ST_DCW;
            ST_DCW:  n_state = ST_MIX;
            ST_MIX:  n_state = ST_HOLD;
            ST_HOLD: n_state = ST_SW;
            ST_SW: begin
                mul_a = {21'd0, r_sweep};
                mul_b = LED_K;
                n_state = ST_SW2;
            end
            ST_SW2: begin
                mul_a = {9'd0, r_prod[23:0]};
                mul_b = DIV_M;
                n_state = ST_SW3;
            end
            ST_SW3: begin
                mul_a = {21'd0, r_prod[45:34]};
                mul_b = DIV_D;
                n_state = ST_SW4;
            end
            ST_SW4: n_state = ST_FIN;
            ST_FIN: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        dsum  = $signed({2'b00, i_in_req.depth_knob}) + 14'(i_in_req.depth_cv);
        tsum  = $signed({2'b00, i_in_req.texture_knob}) + 14'(i_in_req.texture_cv);
        swp   = SWEEP_MID + 14'($signed(r_prod[24:12]));
        gsum  = GAIN_MID + 14'($signed(r_prod[24:12]));
        y     = r_acc - $signed(r_prod[43:12]);
        a7    = (16'(r_ain) <<< 3) - 16'(r_ain);
        ph7   = 32'(a7 >>> 3) - r_x;
        ddiff = 33'(r_ph) - 33'(r_dc);
        mix   = (45'(r_ph) <<< 11) + (45'(r_trem) <<< 11) - 45'(r_trem);
        corr  = {2'b00, r_tex} + {1'b0, r_tex, 1'b0};
        corr  = {2'b00, corr[13:2]} + (burst ? CORR_BURST : 14'd0);
        if (corr > CORR_MAX) corr = CORR_MAX;
        hnext = r_hcnt + 5'd1;
        rem   = r_p - r_prod[23:0];
        mask  = ~((32'd1 << r_corr[11:10]) - 32'd1);
        masked = r_held & $signed(mask);
        outv  = ({2'b00, r_lcg[9:0]} < {3'b000, r_corr[11:3]}) ? r_last : masked;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_pph <= '0;
            r_tph <= '0;
            r_dc <= '0;
            r_lcg <= 32'd1;
            r_hcnt <= '0;
            r_held <= '0;
            r_last <= '0;
            r_last_sync <= 1'b0;
            r_stg <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ALLPASS_STAGES; i++) begin
                r_pin[i]  <= '0;
                r_pout[i] <= '0;
            end
        end else begin
            if (r_state == ST_FIN && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)             r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (accept) begin
                    r_ain   <= i_in_req.audio_in;
                    r_rate  <= i_in_req.rate_knob;
                    r_depth <= clamp12(dsum);
                    r_tex   <= clamp12(tsum);
                    r_mode  <= i_in_req.mode_switch;
                    r_sync  <= i_in_req.sync_pulse;
                    r_last_sync <= i_in_req.sync_pulse;
                    if (i_in_req.sync_pulse && !r_last_sync) r_pph <= '0;
                end
                ST_TR: r_pph <= r_pph + (burst ? PINC_BURST : PINC_BASE + r_prod[47:16]);
                ST_PD: begin
                    r_tph  <= r_tph + (burst ? TINC_BURST : TINC_BASE + r_prod[31:0]);
                    r_plfo <= tri_wave(r_pph);
                end
                ST_TD: begin
                    r_tlfo <= tri_wave(r_tph);
                    if (swp < SWEEP_MIN)      r_sweep <= SWEEP_MIN[11:0];
                    else if (swp > SWEEP_MAX) r_sweep <= SWEEP_MAX[11:0];
                    else                      r_sweep <= swp[11:0];
                end
                ST_GAIN: r_gain <= (gsum < 14'sd0) ? 12'd0 : gsum[11:0];
                ST_LCG:  r_trem <= $signed(r_prod[24:11]);
                ST_LCGW: begin
                    r_lcg <= r_prod[31:0] + LCG_ADD;
                    r_x   <= 32'(r_ain);
                    r_stg <= '0;
                end
                ST_AP_B: r_acc <= r_pin[r_stg] + $signed(r_prod[43:12]);
                ST_AP_C: begin
                    r_pin[r_stg]  <= r_x;
                    r_pout[r_stg] <= y;
                    r_x <= y;
                    if (!last_stg) r_stg <= r_stg + STG_W'(1);
                end
                ST_PH:  r_ph <= ph7;
                ST_DC:  r_dc <= r_dc + {{9{ddiff[32]}}, ddiff[32:10]};
                ST_DCW: r_ph <= r_ph - r_dc;
                ST_MIX: begin
                    r_corr <= corr[11:0];
                    if (r_mode == MODE_MIX) r_o <= mix[43:12];
                    else if (burst)         r_o <= r_ph + (r_ph >>> 1);
                    else                    r_o <= r_ph;
                end
                ST_HOLD: begin
                    if (hnext >= {1'b0, r_corr[11:8]} + 5'd1) begin
                        r_held <= r_o;
                        r_hcnt <= '0;
                    end else begin
                        r_hcnt <= hnext;
                    end
                end
                ST_SW2: r_p <= r_prod[23:0];
                ST_SW3: r_q0 <= r_prod[45:34];
                ST_SW4: r_lsw <= r_q0 + ((rem >= DIV_D24) ? 12'd1 : 12'd0);
                ST_FIN: if (out_free) begin
                    r_last <= outv;
                    if (outv < -32'sd2048)     r_out.audio_out <= -12'sd2048;
                    else if (outv > 32'sd2047) r_out.audio_out <= 12'sd2047;
                    else                       r_out.audio_out <= outv[11:0];
                    r_out.phaser_lfo     <= r_plfo;
                    r_out.trem_lfo       <= r_tlfo;
                    r_out.burst_flag     <= burst;
                    r_out.lfo_pulse      <= r_pph[31];
                    r_out.led_rate       <= r_rate;
                    r_out.led_lfo        <= {~r_plfo[11], r_plfo[10:0]};
                    r_out.led_sweep      <= r_lsw;
                    r_out.led_corruption <= r_corr;
                    r_out.led_burst      <= burst;
                    r_out.led_pulse      <= r_sync;
                end
                default: ;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request accepted while busy path not entered");
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg <= STG_W'(ALLPASS_STAGES - 1))
        else $error("allpass stage index out of range");
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hcnt[4])
        else $error("hold counter exceeded max hold length");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result loaded outside final step");

endmodule
